### sv/tws_pkg.sv
// Package: sizes, result kinds, controller states and memory word types of the timing wheel scheduler.
`default_nettype none
package tws_pkg;
    localparam int SLOTS     = 4095;
    localparam int ENTRIES   = 64;
    localparam int TAG_WIDTH = 16;
    localparam int DELAY_W   = 12;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int SUM_W     = ((SLOT_W > DELAY_W) ? SLOT_W : DELAY_W) + 1;

    typedef enum logic [1:0] {
        KIND_EXPIRED   = 2'd0,
        KIND_ACCEPTED  = 2'd1,
        KIND_BAD_DELAY = 2'd2,
        KIND_POOL_FULL = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD_LINK,
        ST_RESP,
        ST_TICK_RD,
        ST_TICK_HEAD,
        ST_WALK_RD,
        ST_WALK_EMIT
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [ENTRY_W-1:0] head;
        logic [ENTRY_W-1:0] tail;
    } slot_word_t;

    typedef struct packed {
        logic               last;
        logic [ENTRY_W-1:0] next;
    } link_word_t;
endpackage
`default_nettype wire

### sv/timing_wheel_scheduler.sv
// Timing wheel scheduler: slot memory, entry link and tag memories, sequencer.
// An add passes ST_ADD_RD, then ST_ADD_WR unless rejected, ST_ADD_LINK if linked behind
// a slot tail, and ST_RESP, which loads its result; ST_IDLE precedes the next word. A tick
// passes ST_TICK_RD, ST_TICK_HEAD, then ST_WALK_RD, ST_WALK_EMIT per expired word (link
// and tag memory read per entry); a held output register stalls the sequencer until
// it drains. After reset a clearing pass writes every slot empty, no word accepted.
`default_nettype none
module timing_wheel_scheduler (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [0:0]                       s_command,
    input  wire  [tws_pkg::DELAY_W-1:0]      s_delay,
    input  wire  [tws_pkg::TAG_WIDTH-1:0]    s_tag,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_kind,
    output logic [tws_pkg::TAG_WIDTH-1:0]    m_tag_res,
    output logic                             m_last
);
    import tws_pkg::*;

    slot_word_t             slot_mem [SLOTS];
    link_word_t             link_mem [ENTRIES];
    logic [TAG_WIDTH-1:0]   tag_mem  [ENTRIES];

    slot_word_t             slot_rd_reg;
    link_word_t             link_rd_reg;
    logic [TAG_WIDTH-1:0]   tag_rd_reg;

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      clr_reg, clr_next;
    logic [SLOT_W-1:0]      pos_reg, pos_next;
    logic [SLOT_W-1:0]      sel_reg, sel_next;
    logic                   bad_reg, bad_next;
    logic [TAG_WIDTH-1:0]   itag_reg, itag_next;
    logic [ENTRY_W-1:0]     ent_reg, ent_next;
    logic [ENTRY_W-1:0]     cur_reg, cur_next;
    logic [ENTRIES-1:0]     free_reg, free_next;
    logic [COUNT_W-1:0]     live_reg, live_next;
    logic [1:0]             rkind_reg, rkind_next;

    logic                   mv_reg, mv_next;
    logic [1:0]             mk_reg, mk_next;
    logic [TAG_WIDTH-1:0]   mt_reg, mt_next;
    logic                   ml_reg, ml_next;

    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_wa;
    slot_word_t             slot_wd;
    logic                   link_we, tag_we;
    logic [ENTRY_W-1:0]     link_wa;
    link_word_t             link_wd;

    logic                   out_free;
    logic [SUM_W-1:0]       sum;
    logic [SLOT_W-1:0]      pos_inc;
    logic [ENTRY_W-1:0]     lowest;

    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mv_reg;
    assign m_kind    = mk_reg;
    assign m_tag_res = mt_reg;
    assign m_last    = ml_reg;

    always_comb begin
        lowest = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (free_reg[i]) begin
                lowest = ENTRY_W'(i);
            end
        end
    end

    always_comb begin
        sum = SUM_W'(pos_reg) + SUM_W'(s_delay);
        if (sum >= SUM_W'(SLOTS)) begin
            sum = sum - SUM_W'(SLOTS);
        end
        pos_inc = (pos_reg == SLOT_W'(SLOTS - 1)) ? '0 : pos_reg + SLOT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rd_reg <= slot_mem[sel_reg];
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (tag_we) begin
            tag_mem[ent_reg] <= itag_reg;
        end
        link_rd_reg <= link_mem[cur_reg];
        tag_rd_reg  <= tag_mem[cur_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pos_reg   <= '0;
            free_reg  <= '1;
            live_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            free_reg  <= free_next;
            live_reg  <= live_next;
            mv_reg    <= mv_next;
        end
        sel_reg   <= sel_next;
        bad_reg   <= bad_next;
        itag_reg  <= itag_next;
        ent_reg   <= ent_next;
        cur_reg   <= cur_next;
        rkind_reg <= rkind_next;
        mk_reg    <= mk_next;
        mt_reg    <= mt_next;
        ml_reg    <= ml_next;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pos_next   = pos_reg;
        sel_next   = sel_reg;
        bad_next   = bad_reg;
        itag_next  = itag_reg;
        ent_next   = ent_reg;
        cur_next   = cur_reg;
        free_next  = free_reg;
        live_next  = live_reg;
        rkind_next = rkind_reg;
        mv_next    = mv_reg && !m_ready;
        mk_next    = mk_reg;
        mt_next    = mt_reg;
        ml_next    = ml_reg;
        slot_we    = 1'b0;
        slot_wa    = sel_reg;
        slot_wd    = slot_rd_reg;
        link_we    = 1'b0;
        link_wa    = ent_reg;
        link_wd    = '0;
        tag_we     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                slot_we = 1'b1;
                slot_wa = clr_reg;
                slot_wd = '0;
                clr_next = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    itag_next = s_tag;
                    if (s_command[0]) begin
                        pos_next   = pos_inc;
                        sel_next   = pos_inc;
                        state_next = ST_TICK_RD;
                    end else begin
                        bad_next   = (s_delay == '0) || (32'(s_delay) >= 32'(SLOTS));
                        sel_next   = SLOT_W'(sum);
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD: begin
                ent_next = lowest;
                if (bad_reg) begin
                    rkind_next = KIND_BAD_DELAY;
                    state_next = ST_RESP;
                end else if (live_reg >= COUNT_W'(ENTRIES)) begin
                    rkind_next = KIND_POOL_FULL;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_ADD_WR;
                end
            end
            ST_ADD_WR: begin
                slot_we       = 1'b1;
                slot_wd.valid = 1'b1;
                slot_wd.head  = slot_rd_reg.valid ? slot_rd_reg.head : ent_reg;
                slot_wd.tail  = ent_reg;
                link_we       = 1'b1;
                link_wd.last  = 1'b1;
                link_wd.next  = '0;
                tag_we        = 1'b1;
                free_next[ent_reg] = 1'b0;
                live_next  = live_reg + COUNT_W'(1);
                rkind_next = KIND_ACCEPTED;
                state_next = slot_rd_reg.valid ? ST_ADD_LINK : ST_RESP;
            end
            ST_ADD_LINK: begin
                link_we      = 1'b1;
                link_wa      = slot_rd_reg.tail;
                link_wd.last = 1'b0;
                link_wd.next = ent_reg;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mk_next    = rkind_reg;
                    mt_next    = itag_reg;
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                state_next = ST_TICK_HEAD;
            end
            ST_TICK_HEAD: begin
                if (!slot_rd_reg.valid) begin
                    state_next = ST_IDLE;
                end else begin
                    slot_we       = 1'b1;
                    slot_wd.valid = 1'b0;
                    cur_next      = slot_rd_reg.head;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_EMIT;
            end
            ST_WALK_EMIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mk_next = KIND_EXPIRED;
                    mt_next = tag_rd_reg;
                    ml_next = link_rd_reg.last;
                    free_next[cur_reg] = 1'b1;
                    if (live_reg != '0) begin
                        live_next = live_reg - COUNT_W'(1);
                    end
                    if (link_rd_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = link_rd_reg.next;
                        state_next = ST_WALK_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### bench/testbench.sv
// Testbench for the timing wheel scheduler: directed and random words, checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import tws_pkg::*;

    localparam int STALL_LIMIT = 30000;

    typedef struct {
        kind_t           kind;
        logic [TAG_WIDTH-1:0] tag;
        logic            last;
    } outcome_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [0:0]           s_command = 1'b0;
    logic [DELAY_W-1:0]   s_delay = '0;
    logic [TAG_WIDTH-1:0] s_tag = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_kind;
    logic [TAG_WIDTH-1:0] m_tag_res;
    logic                 m_last;

    localparam logic [0:0] CMD_ADD  = 1'b0;
    localparam logic [0:0] CMD_TICK = 1'b1;

    timing_wheel_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_delay   (s_delay),
        .s_tag     (s_tag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_tag_res (m_tag_res),
        .m_last    (m_last)
    );

    // wheel model state
    bit                   slot_used [SLOTS];
    int                   slot_first [SLOTS];
    int                   slot_final [SLOTS];
    bit                   link_end [ENTRIES];
    int                   link_next [ENTRIES];
    logic [TAG_WIDTH-1:0] pool_tag [ENTRIES];
    bit                   pool_busy [ENTRIES];
    int                   position = 0;
    int                   live = 0;

    outcome_t pending_results [$];
    int       mismatches = 0;
    bit       idle_on = 1'b1;
    int       stall_left = 0;
    int       quiet_cycles = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [TAG_WIDTH-1:0] rand_tag();
        return TAG_WIDTH'($urandom);
    endfunction

    function automatic void push_result(kind_t k, logic [TAG_WIDTH-1:0] t, logic l);
        outcome_t o;
        o.kind = k;
        o.tag  = t;
        o.last = l;
        pending_results.push_back(o);
    endfunction

    function automatic void wheel_add(int dly, logic [TAG_WIDTH-1:0] t);
        int e;
        int s;
        if (dly < 1 || dly >= SLOTS) begin
            push_result(KIND_BAD_DELAY, t, 1'b1);
            return;
        end
        e = 0;
        while (e < ENTRIES && pool_busy[e]) e++;
        if (live >= ENTRIES || e >= ENTRIES) begin
            push_result(KIND_POOL_FULL, t, 1'b1);
            return;
        end
        s = (position + dly) % SLOTS;
        pool_busy[e] = 1'b1;
        pool_tag[e]  = t;
        link_end[e]  = 1'b1;
        link_next[e] = 0;
        if (slot_used[s]) begin
            link_end[slot_final[s]]  = 1'b0;
            link_next[slot_final[s]] = e;
        end else begin
            slot_used[s]  = 1'b1;
            slot_first[s] = e;
        end
        slot_final[s] = e;
        live++;
        push_result(KIND_ACCEPTED, t, 1'b1);
    endfunction

    function automatic void wheel_tick();
        int cur;
        bit fin;
        position = (position + 1) % SLOTS;
        if (!slot_used[position]) return;
        cur = slot_first[position];
        for (int n = 0; n < ENTRIES; n++) begin
            fin = link_end[cur];
            push_result(KIND_EXPIRED, pool_tag[cur], fin || n == ENTRIES - 1);
            pool_busy[cur] = 1'b0;
            if (live > 0) live--;
            if (fin) break;
            cur = link_next[cur];
        end
        slot_used[position] = 1'b0;
    endfunction

    // valid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_word(logic [0:0] cmd, int dly, logic [TAG_WIDTH-1:0] t);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_delay   <= dly[DELAY_W-1:0];
        s_tag     <= t;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_TICK) wheel_tick();
        else wheel_add(dly, t);
    endtask

    task automatic add(int dly, logic [TAG_WIDTH-1:0] t);
        send_word(CMD_ADD, dly, t);
    endtask

    task automatic tick();
        send_word(CMD_TICK, 0, rand_tag());
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42) add($urandom_range(1, 16), rand_tag());
        else if (r < 48) add($urandom_range(0, 4095), rand_tag());
        else if (r < 52) add($urandom_range(0, 1) ? 0 : $urandom_range(SLOTS, 4095), rand_tag());
        else tick();
    endtask

    task automatic test_directed();
        add(0, 16'h1234);
        add(SLOTS, 16'h0001);
        add(4095, 16'hffff);
        add(1, 16'h0000);
        add(1, 16'hffff);
        add(2, 16'ha5a5);
        add(SLOTS - 1, 16'h5a5a);
        tick();
        tick();
        tick();
        add(3, 16'h0f0f);
        add(3, 16'hf0f0);
        add(3, 16'h00ff);
        repeat (3) tick();
    endtask

    task automatic test_pool_full();
        for (int i = 0; i < ENTRIES; i++) add(1 + i % 8, rand_tag());
        add(5, 16'hdead);
        add(0, 16'hbeef);
        repeat (8) tick();
        add(2, 16'hcafe);
        repeat (2) tick();
    endtask

    // long delays from a non-zero position wrap the slot index
    task automatic test_wrap();
        add(SLOTS - 2, 16'h7777);
        add(SLOTS - 1, 16'h3333);
        add(5, 16'h1111);
        add(1, 16'h2222);
        repeat (8) tick();
    endtask

    task automatic test_random();
        for (int i = 0; i < 240; i++) begin
            if (i % 160 == 80) begin
                repeat (70) add($urandom_range(1, 4), rand_tag());
                i += 70;
            end
            random_word();
        end
        repeat (20) tick();
    endtask

    task automatic test_no_idling();
        idle_on = 1'b0;
        repeat (80) random_word();
        repeat (20) tick();
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: kind %0d tag %h last %b",
                                 m_kind, m_tag_res, m_last);
                end else begin
                    want = pending_results.pop_front();
                    if (m_kind !== want.kind || m_tag_res !== want.tag || m_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected kind %0d tag %h last %b, got kind %0d tag %h last %b",
                                     want.kind, want.tag, want.last, m_kind, m_tag_res, m_last);
                    end
                end
            end
            if (!idle_on) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pool_full();
        test_wrap();
        test_random();
        test_no_idling();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
